FILE: rtl/sen_pkg.sv
// Package for the scaled Euclidean norm block.
// Holds the queue entry type, back-end state type and fixed-point constants.
`timescale 1ns / 1ps
`default_nettype none
package sen_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STRIDE_W = 12;
    localparam int unsigned SSQ_W    = 45;
    localparam int unsigned NORM_W   = 38;
    localparam int unsigned ROOT_W   = 23;
    localparam int unsigned ACC_W    = 46;

    localparam logic [SSQ_W-1:0]  SSQ_ONE  = 45'h001_0000_0000;
    localparam logic [SSQ_W-1:0]  SSQ_MAX  = {SSQ_W{1'b1}};
    localparam logic [NORM_W-1:0] NORM_MAX = {NORM_W{1'b1}};
    localparam logic [ACC_W-1:0]  ROOT_TOP_BIT = 46'h1000_0000_0000;
    localparam logic [32:0]       RATIO_ONE = 33'h1_0000_0000;

    typedef struct packed {
        logic [VALUE_W-1:0] mag;
        logic               acc;
        logic               emit;
        logic               zero;
    } sen_entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQR,
        ST_MULH,
        ST_MULL,
        ST_SUM,
        ST_ROOT,
        ST_NORM,
        ST_OUT
    } sen_state_t;

endpackage
`default_nettype wire

FILE: rtl/sen_front.sv
// Front end: holds the stride register, classifies incoming elements and counts them.
// Depends on sen_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sen_front
    import sen_pkg::*;
#(
    parameter int unsigned MAX_LENGTH = 4096
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [STRIDE_W-1:0] cfg_wdata,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [VALUE_W-1:0]  value,
    input  wire logic                last,
    input  wire logic                empty_req,
    input  wire logic                q_full,
    output logic                     q_push,
    output sen_entry_t               q_entry
);

    localparam int unsigned CNT_W = $clog2(MAX_LENGTH + 1);

    logic signed [STRIDE_W-1:0] stride_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic                       accept;
    logic                       stride_ok;
    logic                       take;
    logic [VALUE_W-1:0]         mag;

    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;
    assign stride_ok = stride_reg > $signed(STRIDE_W'(0));
    assign take      = !empty_req && stride_ok && (count_reg < CNT_W'(MAX_LENGTH));
    assign mag       = value[VALUE_W-1] ? (~value + VALUE_W'(1)) : value;

    always_comb
    begin
        q_entry.mag  = mag;
        q_entry.acc  = take && (mag != '0);
        q_entry.emit = empty_req || last;
        q_entry.zero = empty_req || !stride_ok;
        q_push       = accept && (q_entry.acc || q_entry.emit);
        count_next   = count_reg;
        if (accept)
        begin
            if (q_entry.emit)
                count_next = '0;
            else if (take)
                count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_reg <= STRIDE_W'(1);
            count_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
                stride_reg <= cfg_wdata;
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/sen_fifo.sv
// Two-entry queue between the front end and the back end.
// Depends on sen_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sen_fifo
    import sen_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire sen_entry_t push_entry,
    output logic            full,
    input  wire logic       pop,
    output logic            pop_valid,
    output sen_entry_t      pop_entry
);

    localparam int unsigned DEPTH = 2;

    sen_entry_t mem_reg [DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = count_reg == 2'(DEPTH);
    assign pop_valid = count_reg != 2'd0;
    assign pop_entry = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(DEPTH))
        else $error("queue count out of range");

endmodule
`default_nettype wire

FILE: rtl/sen_back.sv
// Back end: divider, squaring, rescale, square root and norm output register.
// Depends on sen_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sen_back
    import sen_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    input  wire sen_entry_t     q_entry,
    output logic                q_pop,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [NORM_W-1:0]   norm
);

    sen_state_t          state_reg, state_next;
    sen_entry_t          entry_reg, entry_next;
    logic [VALUE_W-1:0]  scale_reg, scale_next;
    logic [SSQ_W-1:0]    ssq_reg, ssq_next;
    logic [VALUE_W-1:0]  big_reg, big_next;
    logic [VALUE_W-1:0]  rem_reg, rem_next;
    logic [VALUE_W-1:0]  quo_reg, quo_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic                grow_reg, grow_next;
    logic                eq_reg, eq_next;
    logic [32:0]         r2_reg, r2_next;
    logic [SSQ_W-1:0]    ph_reg, ph_next;
    logic [31:0]         pl_reg, pl_next;
    logic [ACC_W-1:0]    res_reg, res_next;
    logic [ACC_W-1:0]    rv_reg, rv_next;
    logic [ACC_W-1:0]    bit_reg, bit_next;
    logic [54:0]         prod_reg, prod_next;
    logic                out_valid_reg, out_valid_next;
    logic [NORM_W-1:0]   norm_reg, norm_next;

    logic [32:0]         rem2;
    logic [63:0]         sq;
    logic [63:0]         lo_prod;
    logic [46:0]         sum;
    logic [ACC_W-1:0]    trial;
    logic [38:0]         shifted;

    assign out_valid = out_valid_reg;
    assign norm      = norm_reg;

    always_comb
    begin
        state_next     = state_reg;
        entry_next     = entry_reg;
        scale_next     = scale_reg;
        ssq_next       = ssq_reg;
        big_next       = big_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        grow_next      = grow_reg;
        eq_next        = eq_reg;
        r2_next        = r2_reg;
        ph_next        = ph_reg;
        pl_next        = pl_reg;
        res_next       = res_reg;
        rv_next        = rv_reg;
        bit_next       = bit_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg && !out_ready;
        norm_next      = norm_reg;
        q_pop          = 1'b0;

        rem2    = {rem_reg, 1'b0};
        sq      = quo_reg * quo_reg;
        lo_prod = ssq_reg[31:0] * r2_reg[31:0];
        sum     = grow_reg ? (47'(ph_reg) + 47'(pl_reg) + 47'(SSQ_ONE))
                           : (47'(ssq_reg) + 47'(r2_reg));
        trial   = res_reg + bit_reg;
        shifted = prod_reg[54:16];

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    entry_next = q_entry;
                    if (q_entry.acc)
                    begin
                        grow_next  = scale_reg < q_entry.mag;
                        eq_next    = scale_reg == q_entry.mag;
                        big_next   = (scale_reg < q_entry.mag) ? q_entry.mag : scale_reg;
                        rem_next   = (scale_reg < q_entry.mag) ? scale_reg : q_entry.mag;
                        quo_next   = '0;
                        cnt_next   = '0;
                        state_next = ST_DIV;
                    end
                    else if (q_entry.zero)
                    begin
                        prod_next  = '0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        rv_next    = ACC_W'(ssq_reg);
                        res_next   = '0;
                        bit_next   = ROOT_TOP_BIT;
                        cnt_next   = '0;
                        state_next = ST_ROOT;
                    end
                end
            end
            ST_DIV:
            begin
                if (rem2 >= 33'(big_reg))
                begin
                    rem_next = 32'(rem2 - 33'(big_reg));
                    quo_next = {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = rem2[31:0];
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                    state_next = ST_SQR;
            end
            ST_SQR:
            begin
                r2_next    = eq_reg ? RATIO_ONE : {1'b0, sq[63:32]};
                state_next = grow_reg ? ST_MULH : ST_SUM;
            end
            ST_MULH:
            begin
                ph_next    = ssq_reg[44:32] * r2_reg[31:0];
                state_next = ST_MULL;
            end
            ST_MULL:
            begin
                pl_next    = lo_prod[63:32];
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                ssq_next = (sum > 47'(SSQ_MAX)) ? SSQ_MAX : sum[SSQ_W-1:0];
                if (grow_reg)
                    scale_next = entry_reg.mag;
                if (entry_reg.emit)
                begin
                    rv_next    = ACC_W'(ssq_next);
                    res_next   = '0;
                    bit_next   = ROOT_TOP_BIT;
                    cnt_next   = '0;
                    state_next = entry_reg.zero ? ST_OUT : ST_ROOT;
                    prod_next  = '0;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ROOT:
            begin
                if (rv_reg >= trial)
                begin
                    rv_next  = rv_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(ROOT_W - 1))
                    state_next = ST_NORM;
            end
            ST_NORM:
            begin
                prod_next  = scale_reg * res_reg[ROOT_W-1:0];
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    norm_next      = (shifted > 39'(NORM_MAX)) ? NORM_MAX
                                                               : shifted[NORM_W-1:0];
                    scale_next     = '0;
                    ssq_next       = SSQ_ONE;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scale_reg     <= '0;
            ssq_reg       <= SSQ_ONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scale_reg     <= scale_next;
            ssq_reg       <= ssq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        big_reg   <= big_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        cnt_reg   <= cnt_next;
        grow_reg  <= grow_next;
        eq_reg    <= eq_next;
        r2_reg    <= r2_next;
        ph_reg    <= ph_next;
        pl_reg    <= pl_next;
        res_reg   <= res_next;
        rv_reg    <= rv_next;
        bit_reg   <= bit_next;
        prod_reg  <= prod_next;
        norm_reg  <= norm_next;
    end

    a_ssq_floor: assert property (@(posedge clk) disable iff (!rst_n)
        ssq_reg >= SSQ_ONE)
        else $error("sum of squares below one");

    a_fresh_state: assert property (@(posedge clk) disable iff (!rst_n)
        scale_reg == '0 |-> ssq_reg == SSQ_ONE)
        else $error("sum changed with zero scale");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> rem_reg <= big_reg)
        else $error("divider remainder above divisor");

endmodule
`default_nettype wire

FILE: rtl/scaled_euclidean_norm.sv
// Scaled Euclidean norm: streams vector elements, gives the overflow-free norm.
// The back end takes no new element until it is through with an accumulated one: divide, square and sum,
// plus two multiply steps when it sets a new scale; a last element then adds a 23-step square root, multiply, output.
// Non-last zero or skipped elements are not queued; empty vectors or a stride not above zero go straight to output.
// A two-entry queue lets input acceptance run ahead of the back end.
// Reset (rst_n, async low) sets stride to 1 and restarts the accumulation.
`timescale 1ns / 1ps
`default_nettype none
module scaled_euclidean_norm
    import sen_pkg::*;
#(
    parameter int unsigned MAX_LENGTH = 4096
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [STRIDE_W-1:0] cfg_wdata,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [VALUE_W-1:0]  value,
    input  wire logic                last,
    input  wire logic                empty_req,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [NORM_W-1:0]        norm
);

    logic       q_full;
    logic       q_push;
    logic       q_pop;
    logic       q_valid;
    sen_entry_t push_entry;
    sen_entry_t pop_entry;

    sen_front #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .last      (last),
        .empty_req (empty_req),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (push_entry)
    );

    sen_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_entry  (pop_entry)
    );

    sen_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (pop_entry),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .norm      (norm)
    );

endmodule
`default_nettype wire
